// ----- design/ipst_pkg.sv -----
// ipst_pkg: types and constants shared by the interval packet statistics design.
// No dependencies.
package ipst_pkg;

  typedef struct packed {
    logic [31:0] timestamp_seconds;
    logic [15:0] total_length;
    logic [1:0]  protocol_kind;
    logic [3:0]  tcp_header_words;
    logic        tcp_push;
    logic [31:0] source_address;
  } in_item_t;

  typedef struct packed {
    logic [31:0] interval_end;
    logic        direction;
    logic [4:0]  statistic_index;
    logic [31:0] statistic_value;
    logic        last_of_run;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_RPT_RD,
    ST_RPT_OUT,
    ST_ALIGN_WAIT,
    ST_UPD,
    ST_UPD_LAST
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_clear;
  } ctr_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } align_status_t;

  localparam int unsigned PADDR_W = 4;

  localparam logic [1:0] REG_INTERVAL_LENGTH = 2'd0;
  localparam logic [1:0] REG_LOCAL_ADDRESS   = 2'd1;
  localparam logic [1:0] REG_START_TIME      = 2'd2;

  localparam logic [31:0] LENGTH_RESET = 32'd60;

  localparam logic [1:0] KIND_TCP = 2'd0;
  localparam logic [1:0] KIND_UDP = 2'd1;

  // per-direction statistic slots, also the update op sequence
  localparam logic [2:0] STAT_PACKETS   = 3'd0;
  localparam logic [2:0] STAT_PAYLOAD   = 3'd1;
  localparam logic [2:0] STAT_PUSH      = 3'd2;
  localparam logic [2:0] STAT_UDP_BYTES = 3'd3;
  localparam logic [2:0] STAT_UDP_COUNT = 3'd4;
  localparam logic [2:0] STAT_BIN       = 3'd5;
  localparam int unsigned NUM_FIXED_STATS = 5;

  localparam logic [15:0] HDR_UDP = 16'd8;

  // total_length / 100 as (total_length * 5243) >> 19, exact below 43699,
  // well past the bin cap
  localparam int unsigned BIN_PROD_W = 29;
  localparam int unsigned BIN_SHIFT  = 19;
  localparam int unsigned BIN_Q_W    = 10;
  localparam logic [BIN_PROD_W-1:0] BIN_RECIP = 29'd5243;

endpackage

// ----- design/interval_packet_statistics_unit.sv -----
// interval_packet_statistics_unit: top level, register port and sequencer.
// Depends on ipst_pkg, ipst_align and ipst_ctr.
// Occupancy: a TCP or UDP packet holds the block after its accept for the check,
// six counter read-modify-writes through one adder and a last write; another kind for the check only.
// A rollover adds a memory read and then an output for each of 2*(5+SIZE_BINS) report beats,
// then an align wait state, plus waits while the output is stalled.
// A start_time write runs the align unit; input stalls meanwhile.
// Reset: synchronous; afterwards a clearing pass over all 2*(5+SIZE_BINS) counter entries.
module interval_packet_statistics_unit #(
  parameter int unsigned SIZE_BINS     = 16,
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pkt_valid,
  output logic                          pkt_stall,
  input  ipst_pkg::in_item_t            pkt,
  output logic                          rpt_valid,
  input  logic                          rpt_stall,
  output ipst_pkg::out_item_t           rpt,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ipst_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int unsigned NSTATS = ipst_pkg::NUM_FIXED_STATS + SIZE_BINS;
  localparam int unsigned DEPTH  = 2 * NSTATS;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned IW     = $clog2(NSTATS);
  localparam int unsigned BW     = $clog2(SIZE_BINS);
  localparam int unsigned CW     = COUNTER_WIDTH;
  localparam logic [ipst_pkg::BIN_Q_W-1:0] BINS_Q = ipst_pkg::BIN_Q_W'(SIZE_BINS);

  ipst_pkg::state_t state;
  ipst_pkg::state_t state_next;

  logic [31:0] interval_length;
  logic [31:0] local_address;
  logic [31:0] start_time;
  logic [31:0] interval_start;
  logic [31:0] leff;

  logic        apb_wr;
  logic [1:0]  reg_idx;

  // latched packet
  logic [31:0] ts;
  logic [1:0]  kind;
  logic        push;
  logic        pkt_dir;
  logic [15:0] payload;
  logic [ipst_pkg::BIN_Q_W-1:0] bin_q;
  logic [BW-1:0] bin_idx;

  logic [15:0] hdr_in;
  logic [15:0] payload_in;
  logic [ipst_pkg::BIN_PROD_W-1:0] bin_prod;

  logic [31:0] end_time;
  logic [31:0] delta;
  logic        roll;
  logic        counted;

  logic [AW-1:0] sweep_addr;
  logic [IW-1:0] rpt_idx;
  logic          rpt_dir;
  logic          rpt_last;
  logic [AW-1:0] rpt_addr;
  logic [IW+4:0] idx_wide;
  logic [CW+31:0] val_wide;

  logic [2:0]    upd_op;
  logic [AW-1:0] op_addr;
  logic [CW-1:0] op_add;
  logic [AW-1:0] pend_addr;
  logic [CW-1:0] pend_add;

  ipst_pkg::ctr_cmd_t cmd;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [CW-1:0] addend;
  logic [CW-1:0] rdata;

  logic        align_start;
  logic [31:0] align_value;
  logic [31:0] aligned;
  ipst_pkg::align_status_t align_st;

  logic pkt_acc;
  logic rpt_acc;

  ipst_align u_align (
    .clk     (clk),
    .rst     (rst),
    .start   (align_start),
    .value   (align_value),
    .modulus (leff),
    .aligned (aligned),
    .status  (align_st)
  );

  ipst_ctr #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctr (
    .clk     (clk),
    .cmd     (cmd),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .addend  (addend),
    .rdata   (rdata)
  );

  // register port
  assign pready  = 1'b1;
  assign apb_wr  = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];
  assign leff    = (interval_length == 32'd0) ? 32'd1 : interval_length;

  always_comb begin
    case (reg_idx)
      ipst_pkg::REG_INTERVAL_LENGTH: prdata = interval_length;
      ipst_pkg::REG_LOCAL_ADDRESS:   prdata = local_address;
      ipst_pkg::REG_START_TIME:      prdata = start_time;
      default:                       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_length <= ipst_pkg::LENGTH_RESET;
      local_address   <= '0;
      start_time      <= '0;
    end else if (apb_wr) begin
      case (reg_idx)
        ipst_pkg::REG_INTERVAL_LENGTH: interval_length <= pwdata;
        ipst_pkg::REG_LOCAL_ADDRESS:   local_address   <= pwdata;
        ipst_pkg::REG_START_TIME:      start_time      <= pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_start <= '0;
    end else if (align_st.done) begin
      interval_start <= aligned;
    end
  end

  // packet front end
  assign hdr_in = (pkt.protocol_kind == ipst_pkg::KIND_TCP) ?
                  {10'd0, pkt.tcp_header_words, 2'b00} : ipst_pkg::HDR_UDP;
  assign payload_in = (pkt.total_length > hdr_in) ? pkt.total_length - hdr_in : '0;
  assign bin_prod = ipst_pkg::BIN_PROD_W'(pkt.total_length) * ipst_pkg::BIN_RECIP;

  assign delta   = ts - interval_start;
  assign roll    = (ts > interval_start) && (delta > leff);
  assign counted = (kind == ipst_pkg::KIND_TCP) || (kind == ipst_pkg::KIND_UDP);

  assign pkt_acc = pkt_valid & ~pkt_stall;
  assign rpt_acc = rpt_valid & ~rpt_stall;

  // report addressing
  assign rpt_last = rpt_dir && (rpt_idx == IW'(NSTATS - 1));
  assign rpt_addr = rpt_dir ? AW'(NSTATS) + AW'(rpt_idx) : AW'(rpt_idx);
  assign idx_wide = {5'd0, rpt_idx};
  assign val_wide = {32'd0, rdata};

  assign rpt.interval_end    = end_time;
  assign rpt.direction       = rpt_dir;
  assign rpt.statistic_index = idx_wide[4:0];
  assign rpt.statistic_value = val_wide[31:0];
  assign rpt.last_of_run     = rpt_last;

  // update op address and increment
  always_comb begin
    if (upd_op == ipst_pkg::STAT_BIN) begin
      op_addr = (pkt_dir ? AW'(NSTATS) : AW'(0)) + AW'(ipst_pkg::NUM_FIXED_STATS)
                + AW'(bin_idx);
    end else begin
      op_addr = (pkt_dir ? AW'(NSTATS) : AW'(0)) + AW'(upd_op);
    end
    case (upd_op)
      ipst_pkg::STAT_PACKETS:   op_add = CW'(1);
      ipst_pkg::STAT_PAYLOAD:   op_add = CW'(payload);
      ipst_pkg::STAT_PUSH:      op_add = CW'(push && (kind == ipst_pkg::KIND_TCP));
      ipst_pkg::STAT_UDP_BYTES: op_add = (kind == ipst_pkg::KIND_UDP) ? CW'(payload) : '0;
      ipst_pkg::STAT_UDP_COUNT: op_add = CW'(kind == ipst_pkg::KIND_UDP);
      default:                  op_add = CW'(1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ipst_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    pkt_stall   = 1'b1;
    rpt_valid   = 1'b0;
    cmd         = '0;
    rd_addr     = '0;
    wr_addr     = '0;
    addend      = '0;
    align_start = apb_wr && (reg_idx == ipst_pkg::REG_START_TIME);
    align_value = pwdata;
    case (state)
      ipst_pkg::ST_CLEAR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_clear = 1'b1;
        wr_addr      = sweep_addr;
        if (sweep_addr == AW'(DEPTH - 1)) begin
          state_next = ipst_pkg::ST_IDLE;
        end
      end
      ipst_pkg::ST_IDLE: begin
        pkt_stall = align_st.busy | align_st.done;
        if (pkt_acc) begin
          state_next = ipst_pkg::ST_CHECK;
        end
      end
      ipst_pkg::ST_CHECK: begin
        if (roll) begin
          align_start = 1'b1;
          align_value = ts;
          state_next  = ipst_pkg::ST_RPT_RD;
        end else if (counted) begin
          state_next = ipst_pkg::ST_UPD;
        end else begin
          state_next = ipst_pkg::ST_IDLE;
        end
      end
      ipst_pkg::ST_RPT_RD: begin
        cmd.rd_en  = 1'b1;
        rd_addr    = rpt_addr;
        state_next = ipst_pkg::ST_RPT_OUT;
      end
      ipst_pkg::ST_RPT_OUT: begin
        rpt_valid = 1'b1;
        if (!rpt_stall) begin
          cmd.wr_en    = 1'b1;
          cmd.wr_clear = 1'b1;
          wr_addr      = rpt_addr;
          state_next   = rpt_last ? ipst_pkg::ST_ALIGN_WAIT : ipst_pkg::ST_RPT_RD;
        end
      end
      ipst_pkg::ST_ALIGN_WAIT: begin
        if (!align_st.busy) begin
          state_next = counted ? ipst_pkg::ST_UPD : ipst_pkg::ST_IDLE;
        end
      end
      ipst_pkg::ST_UPD: begin
        cmd.rd_en = 1'b1;
        rd_addr   = op_addr;
        if (upd_op != ipst_pkg::STAT_PACKETS) begin
          cmd.wr_en = 1'b1;
          wr_addr   = pend_addr;
          addend    = pend_add;
        end
        if (upd_op == ipst_pkg::STAT_BIN) begin
          state_next = ipst_pkg::ST_UPD_LAST;
        end
      end
      ipst_pkg::ST_UPD_LAST: begin
        cmd.wr_en  = 1'b1;
        wr_addr    = pend_addr;
        addend     = pend_add;
        state_next = ipst_pkg::ST_IDLE;
      end
      default: begin
        state_next = ipst_pkg::ST_IDLE;
      end
    endcase
  end

  // sequencer counters
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
      rpt_idx    <= '0;
      rpt_dir    <= 1'b0;
      upd_op     <= ipst_pkg::STAT_PACKETS;
    end else begin
      if (state == ipst_pkg::ST_CLEAR) begin
        sweep_addr <= sweep_addr + AW'(1);
      end
      if (state == ipst_pkg::ST_CHECK) begin
        rpt_idx <= '0;
        rpt_dir <= 1'b0;
        upd_op  <= ipst_pkg::STAT_PACKETS;
      end else if ((state == ipst_pkg::ST_RPT_OUT) && rpt_acc) begin
        if (rpt_idx == IW'(NSTATS - 1)) begin
          rpt_idx <= '0;
          rpt_dir <= 1'b1;
        end else begin
          rpt_idx <= rpt_idx + IW'(1);
        end
      end else if (state == ipst_pkg::ST_UPD) begin
        upd_op <= upd_op + 3'd1;
      end
    end
  end

  // packet and op payload registers
  always_ff @(posedge clk) begin
    if (pkt_acc) begin
      ts      <= pkt.timestamp_seconds;
      kind    <= pkt.protocol_kind;
      push    <= pkt.tcp_push;
      pkt_dir <= (pkt.source_address != local_address);
      payload <= payload_in;
      bin_q   <= bin_prod[ipst_pkg::BIN_SHIFT +: ipst_pkg::BIN_Q_W];
    end
    if (state == ipst_pkg::ST_CHECK) begin
      end_time <= interval_start + leff;
      bin_idx  <= (bin_q >= BINS_Q) ? BW'(SIZE_BINS - 1) : bin_q[BW-1:0];
    end
    if (state == ipst_pkg::ST_UPD) begin
      pend_addr <= op_addr;
      pend_add  <= op_add;
    end
  end

endmodule

// ----- design/ipst_align.sv -----
// ipst_align: rounds a value down to a multiple of a modulus with a
// restoring remainder, one quotient bit per cycle. Depends on ipst_pkg.
module ipst_align (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [31:0]            value,
  input  logic [31:0]            modulus,
  output logic [31:0]            aligned,
  output ipst_pkg::align_status_t status
);

  logic        running;
  logic        finish;
  logic        done;
  logic [4:0]  step;
  logic [31:0] orig;
  logic [31:0] dvd;
  logic [31:0] dvs;
  logic [31:0] rem;
  logic [32:0] trial;
  logic [32:0] diff;
  logic [31:0] rem_next;

  always_comb begin
    trial = {rem, dvd[31]};
    diff  = trial - {1'b0, dvs};
    if (trial >= {1'b0, dvs}) begin
      rem_next = diff[31:0];
    end else begin
      rem_next = trial[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      finish  <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        finish  <= 1'b0;
        step    <= '0;
      end else if (running) begin
        step <= step + 5'd1;
        if (step == 5'd31) begin
          running <= 1'b0;
          finish  <= 1'b1;
        end
      end else if (finish) begin
        finish <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      orig <= value;
      dvd  <= value;
      dvs  <= modulus;
      rem  <= '0;
    end else if (running) begin
      rem <= rem_next;
      dvd <= {dvd[30:0], 1'b0};
    end else if (finish) begin
      aligned <= orig - rem;
    end
  end

  assign status.busy = running | finish;
  assign status.done = done;

endmodule

// ----- design/ipst_ctr.sv -----
// ipst_ctr: counter memory with its read-modify-write adder.
// Depends on ipst_pkg.
module ipst_ctr #(
  parameter int unsigned DEPTH = 42,
  parameter int unsigned AW    = 6,
  parameter int unsigned CW    = 32
) (
  input  logic                clk,
  input  ipst_pkg::ctr_cmd_t  cmd,
  input  logic [AW-1:0]       rd_addr,
  input  logic [AW-1:0]       wr_addr,
  input  logic [CW-1:0]       addend,
  output logic [CW-1:0]       rdata
);

  logic [CW-1:0] mem [DEPTH];
  logic [CW-1:0] wdata;

  // rdata holds the entry read in the previous read cycle
  assign wdata = cmd.wr_clear ? '0 : rdata + addend;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

endmodule

// ----- design/ipst_checker.sv -----
// ipst_checker: port-level assertions for interval_packet_statistics_unit,
// bound to the top level. Depends on ipst_pkg.
module ipst_checker (
  input logic                clk,
  input logic                rst,
  input logic                pkt_stall,
  input logic                rpt_valid,
  input logic                rpt_stall,
  input ipst_pkg::out_item_t rpt
);

  // reset starts the clearing pass, so input is held off
  a_reset_stall: assert property (@(posedge clk) rst |=> pkt_stall)
    else $error("input not stalled after reset");

  a_report_blocks_input: assert property (@(posedge clk) disable iff (rst)
    rpt_valid |-> pkt_stall)
    else $error("input accepted while a report beat is pending");

  a_last_is_incoming: assert property (@(posedge clk) disable iff (rst)
    (rpt_valid && rpt.last_of_run) |-> rpt.direction)
    else $error("last beat of a run not in the incoming direction");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (rpt_valid && !rpt_stall && rpt.last_of_run) |=> !rpt_valid)
    else $error("beat follows the last beat of a run");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (rpt_valid && rpt_stall) |=> (rpt_valid && $stable(rpt)))
    else $error("report beat changed while stalled");

endmodule

bind interval_packet_statistics_unit ipst_checker u_ipst_checker (
  .clk       (clk),
  .rst       (rst),
  .pkt_stall (pkt_stall),
  .rpt_valid (rpt_valid),
  .rpt_stall (rpt_stall),
  .rpt       (rpt)
);

// ----- sim/tb_interval_packet_statistics_unit.sv -----
// Self-checking testbench for interval_packet_statistics_unit: packet beats in, interval
// report beats out, registers over the APB port, an in-bench predictor of the counters.
// Depends on ipst_pkg and the design sources.
`timescale 1ns / 100ps

module tb_interval_packet_statistics_unit;

  localparam int NUM_BINS  = 16;
  localparam int NUM_STATS = ipst_pkg::NUM_FIXED_STATS + NUM_BINS;
  localparam int BIN_BYTES = 100;
  localparam int STUCK_LIMIT = 4000;
  localparam logic [1:0] KIND_OTHER = 2'd2;
  localparam logic [1:0] KIND_RSVD  = 2'd3;

  logic clk;
  logic rst;
  logic pkt_valid;
  logic pkt_stall;
  ipst_pkg::in_item_t pkt;
  logic rpt_valid;
  logic rpt_stall;
  ipst_pkg::out_item_t rpt;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ipst_pkg::PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  interval_packet_statistics_unit dut (
    .clk(clk),
    .rst(rst),
    .pkt_valid(pkt_valid),
    .pkt_stall(pkt_stall),
    .pkt(pkt),
    .rpt_valid(rpt_valid),
    .rpt_stall(rpt_stall),
    .rpt(rpt),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // predictor state
  logic [31:0] ivl_len;
  logic [31:0] own_addr;
  logic [31:0] ivl_start;
  logic [31:0] tally [2][NUM_STATS];
  ipst_pkg::out_item_t report_beats_due[$];

  int faults;
  int stuck_cycles = 0;
  bit calm;
  logic [31:0] last_ts;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic note_fault(input string msg);
    faults++;
    if (faults <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  function automatic logic [31:0] eff_len();
    return (ivl_len == 32'd0) ? 32'd1 : ivl_len;
  endfunction

  function automatic ipst_pkg::in_item_t pkt_of(input logic [31:0] ts,
                                                input logic [15:0] tlen,
                                                input logic [1:0] kind,
                                                input logic [3:0] words,
                                                input logic push,
                                                input logic [31:0] src);
    ipst_pkg::in_item_t p;
    p.timestamp_seconds = ts;
    p.total_length = tlen;
    p.protocol_kind = kind;
    p.tcp_header_words = words;
    p.tcp_push = push;
    p.source_address = src;
    return p;
  endfunction

  task automatic clear_tally();
    foreach (tally[d, s]) tally[d][s] = 32'd0;
  endtask

  // report on rollover, then count the packet
  task automatic tally_packet(input ipst_pkg::in_item_t p);
    logic [31:0] span;
    logic [31:0] stop;
    logic [15:0] hdr;
    logic [15:0] pay;
    int bin;
    int d;
    ipst_pkg::out_item_t b;
    span = eff_len();
    if (p.timestamp_seconds > ivl_start && (p.timestamp_seconds - ivl_start) > span) begin
      stop = ivl_start + span;
      for (int dd = 0; dd < 2; dd++) begin
        for (int s = 0; s < NUM_STATS; s++) begin
          b.interval_end = stop;
          b.direction = dd[0];
          b.statistic_index = 5'(s);
          b.statistic_value = tally[dd][s];
          b.last_of_run = (dd == 1 && s == NUM_STATS - 1);
          report_beats_due.push_back(b);
        end
      end
      clear_tally();
      ivl_start = p.timestamp_seconds - (p.timestamp_seconds % span);
    end
    if (p.protocol_kind == ipst_pkg::KIND_TCP || p.protocol_kind == ipst_pkg::KIND_UDP) begin
      d = (p.source_address == own_addr) ? 0 : 1;
      hdr = (p.protocol_kind == ipst_pkg::KIND_TCP) ?
            {10'd0, p.tcp_header_words, 2'b00} : 16'd8;
      pay = (p.total_length > hdr) ? p.total_length - hdr : 16'd0;
      bin = p.total_length / BIN_BYTES;
      if (bin > NUM_BINS - 1) bin = NUM_BINS - 1;
      tally[d][int'(ipst_pkg::STAT_BIN) + bin] += 32'd1;
      tally[d][ipst_pkg::STAT_PACKETS] += 32'd1;
      tally[d][ipst_pkg::STAT_PAYLOAD] += {16'd0, pay};
      if (p.protocol_kind == ipst_pkg::KIND_TCP && p.tcp_push)
        tally[d][ipst_pkg::STAT_PUSH] += 32'd1;
      if (p.protocol_kind == ipst_pkg::KIND_UDP) begin
        tally[d][ipst_pkg::STAT_UDP_BYTES] += {16'd0, pay};
        tally[d][ipst_pkg::STAT_UDP_COUNT] += 32'd1;
      end
    end
  endtask

  task automatic send_packet(input ipst_pkg::in_item_t p);
    while (!calm && $urandom_range(99) < 9) begin
      pkt_valid <= 1'b0;
      @(posedge clk);
    end
    pkt_valid <= 1'b1;
    pkt <= p;
    @(posedge clk);
    while (pkt_stall) @(posedge clk);
    tally_packet(p);
    last_ts = p.timestamp_seconds;
  endtask

  // drain all report beats, then give the last packet time to finish its updates
  task automatic wait_idle();
    pkt_valid <= 1'b0;
    while (report_beats_due.size() != 0) @(posedge clk);
    repeat (48) @(posedge clk);
  endtask

  task automatic read_check(input logic [1:0] idx, input logic [31:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want)
      note_fault($sformatf("register %0d read: expected %h got %h", idx, want, prdata));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      ipst_pkg::REG_INTERVAL_LENGTH: ivl_len = val;
      ipst_pkg::REG_LOCAL_ADDRESS: own_addr = val;
      ipst_pkg::REG_START_TIME: begin
        ivl_start = val - (val % eff_len());
        last_ts = ivl_start;
      end
      default: ;
    endcase
    read_check(idx, val);
    // start_time write kicks off the align unit
    repeat (40) @(posedge clk);
  endtask

  task automatic test_reset_values();
    read_check(ipst_pkg::REG_INTERVAL_LENGTH, ipst_pkg::LENGTH_RESET);
    read_check(ipst_pkg::REG_LOCAL_ADDRESS, 32'd0);
    read_check(ipst_pkg::REG_START_TIME, 32'd0);
    // default interval: rollover at 61, reported end 60
    send_packet(pkt_of(32'd61, 16'd40, ipst_pkg::KIND_TCP, 4'd5, 1'b1, 32'd0));
    wait_idle();
  endtask

  task automatic test_directed();
    logic [31:0] me;
    me = 32'hC0A8_0001;
    write_reg(ipst_pkg::REG_INTERVAL_LENGTH, 32'd10);
    write_reg(ipst_pkg::REG_LOCAL_ADDRESS, me);
    write_reg(ipst_pkg::REG_START_TIME, 32'd1003);
    send_packet(pkt_of(32'd1000, 16'd0, ipst_pkg::KIND_TCP, 4'd15, 1'b1, me));
    send_packet(pkt_of(32'd1003, 16'hFFFF, ipst_pkg::KIND_TCP, 4'd0, 1'b0, 32'hFFFF_FFFF));
    send_packet(pkt_of(32'd1005, 16'd5, ipst_pkg::KIND_UDP, 4'd15, 1'b1, me));
    send_packet(pkt_of(32'd1005, 16'd1599, ipst_pkg::KIND_UDP, 4'd0, 1'b0, 32'd0));
    send_packet(pkt_of(32'd1006, 16'd99, ipst_pkg::KIND_TCP, 4'd5, 1'b1, 32'd0));
    send_packet(pkt_of(32'd1006, 16'd100, ipst_pkg::KIND_UDP, 4'd5, 1'b0, me));
    send_packet(pkt_of(32'd1007, 16'd1500, KIND_OTHER, 4'd5, 1'b1, me));
    send_packet(pkt_of(32'd1008, 16'd700, KIND_RSVD, 4'd5, 1'b1, 32'd7));
    send_packet(pkt_of(32'd0, 16'd60, ipst_pkg::KIND_TCP, 4'd5, 1'b1, me));
    send_packet(pkt_of(32'd1010, 16'd60, ipst_pkg::KIND_TCP, 4'd5, 1'b0, me));
    send_packet(pkt_of(32'd1011, 16'd200, KIND_OTHER, 4'd0, 1'b0, me));
    send_packet(pkt_of(32'd1021, 16'd300, ipst_pkg::KIND_TCP, 4'd6, 1'b1, 32'd9));
    send_packet(pkt_of(32'hFFFF_FFFF, 16'hFFFF, ipst_pkg::KIND_UDP, 4'd15, 1'b1,
                       32'hFFFF_FFFF));
    wait_idle();
  endtask

  task automatic test_interval_extremes();
    // zero length counts as one second
    write_reg(ipst_pkg::REG_INTERVAL_LENGTH, 32'd0);
    write_reg(ipst_pkg::REG_START_TIME, 32'd5);
    send_packet(pkt_of(32'd6, 16'd1000, ipst_pkg::KIND_TCP, 4'd5, 1'b1, 32'd1));
    send_packet(pkt_of(32'd7, 16'd20, ipst_pkg::KIND_UDP, 4'd0, 1'b0, 32'hC0A8_0001));
    wait_idle();
    write_reg(ipst_pkg::REG_INTERVAL_LENGTH, 32'hFFFF_FFFF);
    write_reg(ipst_pkg::REG_START_TIME, 32'hFFFF_FFFF);
    send_packet(pkt_of(32'hFFFF_FFFF, 16'd800, ipst_pkg::KIND_TCP, 4'd10, 1'b1, 32'd1));
    send_packet(pkt_of(32'd0, 16'd900, ipst_pkg::KIND_UDP, 4'd10, 1'b1, 32'd2));
    wait_idle();
    write_reg(ipst_pkg::REG_INTERVAL_LENGTH, 32'd1);
    write_reg(ipst_pkg::REG_LOCAL_ADDRESS, 32'd0);
    write_reg(ipst_pkg::REG_START_TIME, 32'd0);
    send_packet(pkt_of(32'd2, 16'd1234, ipst_pkg::KIND_TCP, 4'd8, 1'b1, 32'd0));
    send_packet(pkt_of(32'd4, 16'd64, ipst_pkg::KIND_UDP, 4'd8, 1'b0, 32'd3));
    wait_idle();
  endtask

  task automatic send_random_packet();
    logic [31:0] ts;
    logic [15:0] tlen;
    logic [1:0] kind;
    logic [31:0] src;
    int r;
    r = $urandom_range(99);
    if (r < 80) ts = last_ts + $urandom_range(0, 2 * int'(eff_len() > 50 ? 50 : eff_len()) + 1);
    else if (r < 90) ts = ivl_start - $urandom_range(0, 50);
    else ts = $urandom;
    r = $urandom_range(9);
    kind = (r < 5) ? ipst_pkg::KIND_TCP : (r < 8) ? ipst_pkg::KIND_UDP :
           (r == 8) ? KIND_OTHER : KIND_RSVD;
    tlen = $urandom_range(1) ? 16'($urandom_range(0, 1700)) : 16'($urandom);
    src = $urandom_range(1) ? own_addr : $urandom;
    send_packet(pkt_of(ts, tlen, kind, 4'($urandom), 1'($urandom), src));
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_reg(ipst_pkg::REG_INTERVAL_LENGTH, $urandom_range(1, 20));
        1: write_reg(ipst_pkg::REG_INTERVAL_LENGTH, 32'd1);
        2: write_reg(ipst_pkg::REG_INTERVAL_LENGTH, $urandom_range(2, 50));
        default: write_reg(ipst_pkg::REG_INTERVAL_LENGTH, 32'd0);
      endcase
      write_reg(ipst_pkg::REG_LOCAL_ADDRESS, $urandom);
      write_reg(ipst_pkg::REG_START_TIME, $urandom);
      calm = (ph == 1);
      repeat (25) send_random_packet();
      wait_idle();
      calm = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    rpt_stall <= !calm && ($urandom_range(99) < 9);
  end

  always @(posedge clk) begin
    ipst_pkg::out_item_t want;
    if (!rst && rpt_valid && !rpt_stall) begin
      if (report_beats_due.size() == 0) begin
        note_fault($sformatf("unexpected report beat idx=%0d val=%0d",
                             rpt.statistic_index, rpt.statistic_value));
      end else begin
        want = report_beats_due.pop_front();
        if (rpt.interval_end !== want.interval_end || rpt.direction !== want.direction ||
            rpt.statistic_index !== want.statistic_index ||
            rpt.statistic_value !== want.statistic_value ||
            rpt.last_of_run !== want.last_of_run)
          note_fault($sformatf({"report beat: expected end=%0d dir=%0d idx=%0d val=%0d ",
                                "last=%0d, got end=%0d dir=%0d idx=%0d val=%0d last=%0d"},
                               want.interval_end, want.direction, want.statistic_index,
                               want.statistic_value, want.last_of_run,
                               rpt.interval_end, rpt.direction, rpt.statistic_index,
                               rpt.statistic_value, rpt.last_of_run));
      end
    end
  end

  always @(posedge clk) begin
    if ((pkt_valid && !pkt_stall) || (rpt_valid && !rpt_stall) || (psel && penable && pready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    faults = 0;
    calm = 1'b0;
    ivl_len = ipst_pkg::LENGTH_RESET;
    own_addr = 32'd0;
    ivl_start = 32'd0;
    last_ts = 32'd0;
    clear_tally();
    rst <= 1'b1;
    pkt_valid <= 1'b0;
    pkt <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // counter memory clearing pass
    repeat (60) @(posedge clk);
    test_reset_values();
    test_directed();
    test_interval_extremes();
    test_random_traffic();
    wait_idle();
    if (faults == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
